### rtl/ssa_pkg.sv
// Slab slot allocator: shared codes, field widths and the command/status
// structs between the controller and the datapath. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ssa_pkg;

    // Field widths fixed by the interface
    localparam int ADDR_W    = 32;
    localparam int SIZE_W    = 17;
    localparam int COUNT_W   = 11;
    localparam int STATUS_W  = 3;
    localparam int REQ_W     = 2;
    localparam int CFG_IDX_W = 2;

    // Request codes
    localparam logic [REQ_W-1:0] REQ_INIT  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_ALLOC = 2'd1;
    localparam logic [REQ_W-1:0] REQ_FREE  = 2'd2;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_ALIGN    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NOT_USED = 3'd4;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BASE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COUNT = 2'd2;

    // Controller to datapath
    typedef struct packed {
        logic                load;        // capture the input word
        logic                sweep_step;  // clear one used bit, fill one stack entry
        logic                set_count;   // free count takes the effective slot count
        logic                pop;         // pop stack top, mark used, form product
        logic                add;         // form payload address
        logic                div_start;   // load divider with the slot offset
        logic                div_step;    // one quotient bit
        logic                put_back;    // clear used bit, push slot back
        logic                res_write;   // load the output register
        logic                res_pay;     // result carries the payload address
        logic [STATUS_W-1:0] res_status;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic sweep_last;
        logic empty;
        logic pre_bad;
        logic div_last;
        logic idx_bad;
        logic rem_nz;
        logic used;
        logic out_busy;
    } t_sts;

endpackage

`default_nettype wire

### rtl/ssa_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module ssa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

### rtl/ssa_ctrl.sv
// Slab slot allocator controller: sequences init, allocate and free words
// over the datapath. Depends on ssa_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ssa_ctrl
    import ssa_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    input  wire logic [REQ_W-1:0] i_req_type,
    output logic                  o_in_stall,
    output t_cmd                  o_cmd,
    input  wire t_sts             i_sts
);

    localparam logic [3:0] S_CLEAR     = 4'd0;
    localparam logic [3:0] S_IDLE      = 4'd1;
    localparam logic [3:0] S_INIT      = 4'd2;
    localparam logic [3:0] S_ALLOC     = 4'd3;
    localparam logic [3:0] S_ALLOC_ADD = 4'd4;
    localparam logic [3:0] S_FREE_CHK  = 4'd5;
    localparam logic [3:0] S_DIV       = 4'd6;
    localparam logic [3:0] S_FREE_TEST = 4'd7;
    localparam logic [3:0] S_FREE_UPD  = 4'd8;
    localparam logic [3:0] S_DONE      = 4'd9;

    logic [3:0]          r_state, n_state;
    logic [STATUS_W-1:0] r_status, n_status;
    logic                r_pay, n_pay;
    logic                w_accept;

    assign o_in_stall = (r_state != S_IDLE);
    assign w_accept   = i_in_valid && (r_state == S_IDLE);

    // Next state and commands
    always_comb begin
        n_state  = r_state;
        n_status = r_status;
        n_pay    = r_pay;
        o_cmd    = '0;
        o_cmd.load = w_accept;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.sweep_step = 1'b1;
                if (i_sts.sweep_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_status = ST_OK;
                    n_pay    = 1'b0;
                    unique case (i_req_type)
                        REQ_INIT:  n_state = S_INIT;
                        REQ_ALLOC: n_state = S_ALLOC;
                        REQ_FREE:  n_state = S_FREE_CHK;
                        default:   n_state = S_DONE;
                    endcase
                end
            end
            S_INIT: begin
                o_cmd.sweep_step = 1'b1;
                if (i_sts.sweep_last) begin
                    o_cmd.set_count = 1'b1;
                    n_state         = S_DONE;
                end
            end
            S_ALLOC: begin
                if (i_sts.empty) begin
                    n_status = ST_EMPTY;
                    n_state  = S_DONE;
                end else begin
                    o_cmd.pop = 1'b1;
                    n_state   = S_ALLOC_ADD;
                end
            end
            S_ALLOC_ADD: begin
                o_cmd.add = 1'b1;
                n_pay     = 1'b1;
                n_state   = S_DONE;
            end
            S_FREE_CHK: begin
                if (i_sts.pre_bad) begin
                    n_status = ST_RANGE;
                    n_state  = S_DONE;
                end else begin
                    o_cmd.div_start = 1'b1;
                    n_state         = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = S_FREE_TEST;
                end
            end
            S_FREE_TEST: begin
                // range before boundary; used bit read is in flight
                if (i_sts.idx_bad) begin
                    n_status = ST_RANGE;
                    n_state  = S_DONE;
                end else if (i_sts.rem_nz) begin
                    n_status = ST_ALIGN;
                    n_state  = S_DONE;
                end else begin
                    n_state = S_FREE_UPD;
                end
            end
            S_FREE_UPD: begin
                if (!i_sts.used) begin
                    n_status = ST_NOT_USED;
                end else begin
                    o_cmd.put_back = 1'b1;
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!i_sts.out_busy) begin
                    o_cmd.res_write  = 1'b1;
                    o_cmd.res_pay    = r_pay;
                    o_cmd.res_status = r_status;
                    n_state          = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
        r_status <= n_status;
        r_pay    <= n_pay;
    end

endmodule

`default_nettype wire

### rtl/ssa_dpath.sv
// Slab slot allocator datapath: configuration registers, free stack and
// used-bit RAMs, offset divider, address multiply and output register.
// Depends on ssa_pkg and ssa_ram.
`timescale 1ns / 1ps
`default_nettype none

module ssa_dpath
    import ssa_pkg::*;
#(
    parameter int SLOTS        = 1024,
    parameter int HEADER_BYTES = 8
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_valid,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [ADDR_W-1:0]    i_cfg_data,
    input  wire logic [ADDR_W-1:0]    i_address,
    input  wire t_cmd                 i_cmd,
    output t_sts                      o_sts,
    input  wire logic                 i_out_stall,
    output logic                      o_out_valid,
    output logic [STATUS_W-1:0]       o_status,
    output logic [ADDR_W-1:0]         o_payload_address
);

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W = $clog2(SLOTS + 1);

    logic [ADDR_W-1:0]  r_base;
    logic [SIZE_W-1:0]  r_size;
    logic [COUNT_W-1:0] r_cnt_cfg;

    logic [CNT_W-1:0]   r_free_cnt;
    logic [IDX_W-1:0]   r_sweep;
    logic [ADDR_W-1:0]  r_hdr;
    logic               r_addr_low;
    logic [ADDR_W-1:0]  r_quo;
    logic [SIZE_W-1:0]  r_rem;
    logic [4:0]         r_div_cnt;
    logic [ADDR_W-1:0]  r_prod;
    logic [ADDR_W-1:0]  r_pay;
    logic               r_out_valid;
    logic [STATUS_W-1:0] r_status;
    logic [ADDR_W-1:0]  r_payload;

    logic [CNT_W-1:0]   w_eff;
    logic [CNT_W-1:0]   w_sweep_ext;
    logic               w_fill;
    logic               w_room;
    logic [IDX_W-1:0]   w_quo_idx;
    logic [SIZE_W:0]    w_rem_sh;
    logic               w_ge;

    logic               w_stk_we;
    logic [IDX_W-1:0]   w_stk_waddr, w_stk_wdata, w_stk_raddr, w_stk_rdata;
    logic               w_used_we;
    logic [IDX_W-1:0]   w_used_waddr;
    logic [0:0]         w_used_wdata, w_used_rdata;

    // Effective slot count: configured count limited to SLOTS
    assign w_eff = (32'(r_cnt_cfg) > 32'(SLOTS)) ? CNT_W'(SLOTS) : CNT_W'(r_cnt_cfg);

    assign w_sweep_ext = CNT_W'(r_sweep);
    assign w_fill      = w_sweep_ext < w_eff;
    assign w_room      = 32'(r_free_cnt) < 32'(SLOTS);
    assign w_quo_idx   = r_quo[IDX_W-1:0];

    // Divider step: shift in the next dividend bit, subtract if it fits
    assign w_rem_sh = {r_rem, r_quo[ADDR_W-1]};
    assign w_ge     = w_rem_sh >= (SIZE_W+1)'(r_size);

    // Free stack RAM ports
    assign w_stk_we    = (i_cmd.sweep_step && w_fill) || (i_cmd.put_back && w_room);
    assign w_stk_waddr = i_cmd.sweep_step ? r_sweep : IDX_W'(r_free_cnt);
    assign w_stk_wdata = i_cmd.sweep_step ? IDX_W'(w_eff - w_sweep_ext - CNT_W'(1))
                                          : w_quo_idx;
    assign w_stk_raddr = IDX_W'(r_free_cnt - CNT_W'(1));

    // Used-bit RAM ports; read always follows the quotient
    assign w_used_we    = i_cmd.sweep_step || i_cmd.pop || i_cmd.put_back;
    assign w_used_waddr = i_cmd.sweep_step ? r_sweep :
                          i_cmd.pop        ? w_stk_rdata : w_quo_idx;
    assign w_used_wdata = i_cmd.pop;

    ssa_ram #(
        .WIDTH (IDX_W),
        .DEPTH (SLOTS)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (w_stk_we),
        .i_waddr (w_stk_waddr),
        .i_wdata (w_stk_wdata),
        .i_raddr (w_stk_raddr),
        .o_rdata (w_stk_rdata)
    );

    ssa_ram #(
        .WIDTH (1),
        .DEPTH (SLOTS)
    ) u_used (
        .i_clk   (i_clk),
        .i_we    (w_used_we),
        .i_waddr (w_used_waddr),
        .i_wdata (w_used_wdata),
        .i_raddr (w_quo_idx),
        .o_rdata (w_used_rdata)
    );

    // Status to the controller
    assign o_sts.sweep_last = (r_sweep == IDX_W'(SLOTS - 1));
    assign o_sts.empty      = (r_free_cnt == '0);
    assign o_sts.pre_bad    = r_addr_low || (r_hdr < r_base) || (r_size == '0);
    assign o_sts.div_last   = (r_div_cnt == 5'd31);
    assign o_sts.idx_bad    = r_quo >= 32'(w_eff);
    assign o_sts.rem_nz     = (r_rem != '0);
    assign o_sts.used       = w_used_rdata[0];
    assign o_sts.out_busy   = r_out_valid && i_out_stall;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base    <= '0;
            r_size    <= SIZE_W'(64);
            r_cnt_cfg <= COUNT_W'(1024);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_BASE:  r_base    <= i_cfg_data;
                CFG_SIZE:  r_size    <= i_cfg_data[SIZE_W-1:0];
                CFG_COUNT: r_cnt_cfg <= i_cfg_data[COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    // Free count and sweep counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_free_cnt <= '0;
            r_sweep    <= '0;
        end else begin
            if (i_cmd.set_count) begin
                r_free_cnt <= w_eff;
            end else if (i_cmd.pop) begin
                r_free_cnt <= r_free_cnt - CNT_W'(1);
            end else if (i_cmd.put_back && w_room) begin
                r_free_cnt <= r_free_cnt + CNT_W'(1);
            end
            if (i_cmd.sweep_step) begin
                r_sweep <= o_sts.sweep_last ? '0 : r_sweep + IDX_W'(1);
            end
        end
    end

    // Input capture, divider, address arithmetic
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_hdr      <= i_address - ADDR_W'(HEADER_BYTES);
            r_addr_low <= i_address < ADDR_W'(HEADER_BYTES);
        end
        if (i_cmd.div_start) begin
            r_quo     <= r_hdr - r_base;
            r_rem     <= '0;
            r_div_cnt <= '0;
        end else if (i_cmd.div_step) begin
            r_quo     <= {r_quo[ADDR_W-2:0], w_ge};
            r_rem     <= w_ge ? SIZE_W'(w_rem_sh - (SIZE_W+1)'(r_size))
                              : w_rem_sh[SIZE_W-1:0];
            r_div_cnt <= r_div_cnt + 5'd1;
        end
        if (i_cmd.pop) begin
            r_prod <= ADDR_W'(w_stk_rdata) * ADDR_W'(r_size);
        end
        if (i_cmd.add) begin
            r_pay <= r_base + r_prod + ADDR_W'(HEADER_BYTES);
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.res_write) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
        if (i_cmd.res_write) begin
            r_status  <= i_cmd.res_status;
            r_payload <= i_cmd.res_pay ? r_pay : '0;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_status          = r_status;
    assign o_payload_address = r_payload;

endmodule

`default_nettype wire

### rtl/slab_slot_allocator_core.sv
// Slab slot allocator top level: controller plus datapath.
// Depends on ssa_pkg, ssa_ctrl, ssa_dpath (and ssa_ram below it).
//
// Usage: one request word in (req_type, address), one result word out
// (status, payload_address). A word moves when valid is high and stall low.
// Configuration (slot_base, slot_size, slot_count) is written through the cfg
// channel, index 0..2, while no request is in flight; ready is always high.
// Steps per word, input accept to result loaded in the output register:
//   allocate pops, then adds; unused code goes straight to the result; free runs a
//   bit-serial divider (one quotient bit per cycle over 32 bits) unless rejected early;
//   init sweeps one RAM row per cycle over the used-bit and stack memories.
// One request is in progress at a time; the next one is taken once the
// result is in the output register, even if that is still stalled.
// Reset: synchronous active-low; afterwards a clearing pass over all SLOTS rows
// zeroes the used bits, with the input stalled. The free stack starts empty.
// A stalled result holds; the controller waits before loading the next.
`timescale 1ns / 1ps
`default_nettype none

module slab_slot_allocator_core
    import ssa_pkg::*;
#(
    parameter int SLOTS        = 1024,
    parameter int HEADER_BYTES = 8
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [ADDR_W-1:0]    i_cfg_data,
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire logic [REQ_W-1:0]     i_req_type,
    input  wire logic [ADDR_W-1:0]    i_address,
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output logic [STATUS_W-1:0]       o_status,
    output logic [ADDR_W-1:0]         o_payload_address
);

    t_cmd w_cmd;
    t_sts w_sts;

    assign o_cfg_ready = 1'b1;

    ssa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_req_type (i_req_type),
        .o_in_stall (o_in_stall),
        .o_cmd      (w_cmd),
        .i_sts      (w_sts)
    );

    ssa_dpath #(
        .SLOTS        (SLOTS),
        .HEADER_BYTES (HEADER_BYTES)
    ) u_dpath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_valid       (i_cfg_valid),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_address         (i_address),
        .i_cmd             (w_cmd),
        .o_sts             (w_sts),
        .i_out_stall       (i_out_stall),
        .o_out_valid       (o_out_valid),
        .o_status          (o_status),
        .o_payload_address (o_payload_address)
    );

endmodule

`default_nettype wire

### sim/slab_alloc_checker.sv
// Slab allocator checker: watches the request, reply and register channels of
// the allocator core, predicts every reply word and compares it field by field.
// Depends on ssa_pkg for widths, request, status and register codes.
`timescale 1ns / 1ps

module slab_alloc_checker
    import ssa_pkg::*;
#(
    parameter int SLOTS        = 1024,
    parameter int HEADER_BYTES = 8
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_valid,
    input  wire logic                 i_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [ADDR_W-1:0]    i_cfg_data,
    input  wire logic                 i_in_valid,
    input  wire logic                 i_in_stall,
    input  wire logic [REQ_W-1:0]     i_req_type,
    input  wire logic [ADDR_W-1:0]    i_address,
    input  wire logic                 i_out_valid,
    input  wire logic                 i_out_stall,
    input  wire logic [STATUS_W-1:0]  i_status,
    input  wire logic [ADDR_W-1:0]    i_payload_address,
    output int                        o_mismatches,
    output int                        o_outstanding
);

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ADDR_W-1:0]   payload;
    } t_slab_reply;

    // Shadow registers and allocator state
    logic [ADDR_W-1:0]  base_q;
    logic [SIZE_W-1:0]  size_q;
    logic [COUNT_W-1:0] count_q;
    logic [IDX_W-1:0]   free_stack [SLOTS];
    int unsigned        free_depth;
    logic               in_use [SLOTS];
    t_slab_reply        awaited_replies [$];
    int                 reply_no;

    // Slot count clipped to the number of slots built
    function automatic int unsigned live_slots();
        return (count_q > SLOTS) ? SLOTS : int'(count_q);
    endfunction

    // Applies one request word to the shadow state and returns its reply
    function automatic t_slab_reply model_slab_request(input logic [REQ_W-1:0] kind,
                                                       input logic [ADDR_W-1:0] addr);
        t_slab_reply      r;
        int unsigned      n;
        int               k;
        logic [IDX_W-1:0] slot;
        logic [63:0]      hdr;
        logic [63:0]      off;
        logic [63:0]      idx;
        r.status  = ST_OK;
        r.payload = '0;
        n = live_slots();
        case (kind)
            REQ_INIT: begin
                for (k = 0; k < SLOTS; k++) in_use[k] = 1'b0;
                // slot 0 ends up on top of the stack
                for (k = 0; k < n; k++) free_stack[k] = IDX_W'(n - 1 - k);
                free_depth = n;
            end
            REQ_ALLOC: begin
                if (free_depth == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    free_depth--;
                    slot = free_stack[free_depth];
                    in_use[slot] = 1'b1;
                    r.payload = ADDR_W'(64'(base_q) + 64'(slot) * 64'(size_q)
                                        + 64'(HEADER_BYTES));
                end
            end
            REQ_FREE: begin
                hdr = 64'(addr) - 64'(HEADER_BYTES);
                // range first, then slot boundary, then in use
                if (64'(addr) < 64'(HEADER_BYTES) || hdr < 64'(base_q) || size_q == '0) begin
                    r.status = ST_RANGE;
                end else begin
                    off = hdr - 64'(base_q);
                    idx = off / 64'(size_q);
                    if (idx >= 64'(n)) begin
                        r.status = ST_RANGE;
                    end else if (off % 64'(size_q) != 0) begin
                        r.status = ST_ALIGN;
                    end else if (!in_use[idx]) begin
                        r.status = ST_NOT_USED;
                    end else begin
                        in_use[idx] = 1'b0;
                        if (free_depth < SLOTS) begin
                            free_stack[free_depth] = IDX_W'(idx);
                            free_depth++;
                        end
                    end
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic report_mismatch(input string what);
        if (o_mismatches < 30) $display("[%0t] slab checker: %s", $time, what);
        o_mismatches++;
    endtask

    // Replies are checked before the request of the same edge is predicted
    always @(posedge i_clk) begin : watch_channels
        t_slab_reply want;
        int          k;
        if (!i_rst_n) begin
            base_q     = '0;
            size_q     = SIZE_W'(64);
            count_q    = COUNT_W'(SLOTS);
            free_depth = 0;
            for (k = 0; k < SLOTS; k++) in_use[k] = 1'b0;
            awaited_replies.delete();
            reply_no     = 0;
            o_mismatches = 0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (awaited_replies.size() == 0) begin
                    report_mismatch($sformatf("word %0d unexpected, status %0d payload %h",
                                              reply_no, i_status, i_payload_address));
                end else begin
                    want = awaited_replies.pop_front();
                    if (i_status !== want.status)
                        report_mismatch($sformatf("word %0d status %0d, expected %0d",
                                                  reply_no, i_status, want.status));
                    if (i_payload_address !== want.payload)
                        report_mismatch($sformatf("word %0d payload %h, expected %h",
                                                  reply_no, i_payload_address,
                                                  want.payload));
                end
                reply_no++;
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_BASE:  base_q  = i_cfg_data;
                    CFG_SIZE:  size_q  = i_cfg_data[SIZE_W-1:0];
                    CFG_COUNT: count_q = i_cfg_data[COUNT_W-1:0];
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall)
                awaited_replies.push_back(model_slab_request(i_req_type, i_address));
        end
        o_outstanding = awaited_replies.size();
    end

endmodule

### sim/slab_slot_allocator_core_tb.sv
// Testbench top for the slab slot allocator core: clock, reset, register
// set-up, request stimulus and verdict. Depends on ssa_pkg, the core and
// slab_alloc_checker, which does all the predicting and comparing.
`timescale 1ns / 1ps

module slab_slot_allocator_core_tb;
    import ssa_pkg::*;

    localparam int SLOTS         = 1024;
    localparam int HEADER_BYTES  = 8;
    localparam int RUN_LIMIT     = 1_000_000;
    localparam int HOLD_CYCLES   = 400;
    localparam int PHASES        = 10;
    localparam int PHASE_ITEMS   = 155;
    localparam int SETTLE_CYCLES = 64;

    // Codes with no name in the package
    localparam logic [REQ_W-1:0]     REQ_NONE  = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    bit                   i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [ADDR_W-1:0]    i_cfg_data;
    logic                 i_in_valid;
    logic                 o_in_stall;
    logic [REQ_W-1:0]     i_req_type;
    logic [ADDR_W-1:0]    i_address;
    logic                 o_out_valid;
    logic                 i_out_stall;
    logic [STATUS_W-1:0]  o_status;
    logic [ADDR_W-1:0]    o_payload_address;

    int mismatches;
    int outstanding;

    // Stimulus-side copy of the register values written so far
    logic [ADDR_W-1:0]  tb_base  = '0;
    logic [SIZE_W-1:0]  tb_size  = SIZE_W'(64);
    logic [COUNT_W-1:0] tb_count = COUNT_W'(SLOTS);

    int idle_pct     = 0;
    bit hold_request = 1'b0;

    slab_slot_allocator_core #(
        .SLOTS        (SLOTS),
        .HEADER_BYTES (HEADER_BYTES)
    ) uut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_req_type        (i_req_type),
        .i_address         (i_address),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_status          (o_status),
        .o_payload_address (o_payload_address)
    );

    slab_alloc_checker #(
        .SLOTS        (SLOTS),
        .HEADER_BYTES (HEADER_BYTES)
    ) u_checker (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_valid       (i_cfg_valid),
        .i_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_in_valid        (i_in_valid),
        .i_in_stall        (o_in_stall),
        .i_req_type        (i_req_type),
        .i_address         (i_address),
        .i_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .i_status          (o_status),
        .i_payload_address (o_payload_address),
        .o_mismatches      (mismatches),
        .o_outstanding     (outstanding)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Payload address of a slot under the current layout, wrapping at 2^32
    function automatic logic [ADDR_W-1:0] slot_payload(input int unsigned slot);
        return ADDR_W'(64'(tb_base) + 64'(slot) * 64'(tb_size) + 64'(HEADER_BYTES));
    endfunction

    // Offers one request word; returns on the falling edge after acceptance
    // with valid still high, so back-to-back words need no gap.
    task automatic send_req(input logic [REQ_W-1:0] kind, input logic [ADDR_W-1:0] addr);
        int gap;
        if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
            gap = $urandom_range(1, 5);
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_req_type <= kind;
        i_address  <= addr;
        do @(posedge i_clk); while (o_in_stall);
        @(negedge i_clk);
    endtask

    // Drops valid and waits until every reply word has come back
    task automatic drain_replies();
        i_in_valid <= 1'b0;
        do @(negedge i_clk); while (outstanding != 0);
    endtask

    task automatic write_slab_reg(input logic [CFG_IDX_W-1:0] index,
                                  input logic [ADDR_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        case (index)
            CFG_BASE:  tb_base  = data;
            CFG_SIZE:  tb_size  = data[SIZE_W-1:0];
            CFG_COUNT: tb_count = data[COUNT_W-1:0];
            default: ;
        endcase
    endtask

    task automatic end_cfg_writes();
        i_cfg_valid <= 1'b0;
    endtask

    task automatic program_slab(input logic [ADDR_W-1:0] base, input logic [ADDR_W-1:0] size,
                                input logic [ADDR_W-1:0] count);
        write_slab_reg(CFG_BASE, base);
        write_slab_reg(CFG_SIZE, size);
        write_slab_reg(CFG_COUNT, count);
    endtask

    // Mostly allocations and frees of real slots; the rest is malformed frees,
    // re-inits and the unused request code.
    task automatic send_random_item();
        int unsigned       roll;
        int unsigned       live;
        int unsigned       span;
        logic [ADDR_W-1:0] noise;
        live  = (tb_count > SLOTS) ? SLOTS : int'(tb_count);
        span  = (live == 0) ? 1 : ((live < 24) ? live : 24);
        roll  = $urandom_range(0, 99);
        noise = $urandom;
        if (roll < 2)
            send_req(REQ_INIT, noise);
        else if (roll < 4)
            send_req(REQ_NONE, noise);
        else if (roll < 50)
            send_req(REQ_ALLOC, noise);
        else if (roll < 80)
            send_req(REQ_FREE, slot_payload($urandom_range(0, span - 1)));
        else if (roll < 86)
            send_req(REQ_FREE, slot_payload($urandom_range(0, span - 1))
                               + ((tb_size > 1) ? $urandom_range(1, tb_size - 1) : 1));
        else if (roll < 91)
            send_req(REQ_FREE, slot_payload(live + $urandom_range(0, 3)));
        else if (roll < 95)
            send_req(REQ_FREE, tb_base + HEADER_BYTES - 1 - $urandom_range(0, 15));
        else
            send_req(REQ_FREE, noise);
    endtask

    // Reply side: short random stall bursts, plus one long hold on request
    initial begin : reply_stall
        int burst;
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                i_out_stall <= 1'b0;
            end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
                burst = $urandom_range(1, 5);
                i_out_stall <= 1'b1;
                repeat (burst) @(negedge i_clk);
                i_out_stall <= 1'b0;
            end
        end
    end

    initial begin : run_limit
        int cycles;
        cycles = 0;
        while (cycles < RUN_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("TEST FAILED");
        $finish;
    end

    initial begin : stimulus
        int phase;
        int n;
        i_rst_n     = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_BASE;
        i_cfg_data  = '0;
        i_in_valid  = 1'b0;
        i_req_type  = REQ_INIT;
        i_address   = '0;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Before any init: stack empty, low addresses, unused code
        idle_pct = 15;
        send_req(REQ_ALLOC, 32'h0);
        send_req(REQ_FREE, 32'h0);
        send_req(REQ_FREE, 32'h7);
        send_req(REQ_NONE, 32'hFFFF_FFFF);
        // Reset layout: base 0, 64-byte slots, all slots
        send_req(REQ_INIT, 32'h0);
        send_req(REQ_ALLOC, 32'h0);
        send_req(REQ_ALLOC, 32'h0);
        send_req(REQ_FREE, 32'd72);
        send_req(REQ_FREE, 32'd72);                     // same slot twice
        send_req(REQ_FREE, 32'd73);                     // off boundary
        send_req(REQ_FREE, 32'd8 + 32'd64 * SLOTS);     // one past the last slot
        send_req(REQ_FREE, 32'hFFFF_FFFF);
        send_req(REQ_FREE, 32'd8);
        send_req(REQ_ALLOC, 32'h0);

        // Single 8-byte slot: empty stack, header below base
        drain_replies();
        program_slab(32'h100, 32'd8, 32'd1);
        end_cfg_writes();
        send_req(REQ_INIT, 32'h0);
        send_req(REQ_ALLOC, 32'h0);
        send_req(REQ_ALLOC, 32'h0);
        send_req(REQ_FREE, 32'h20);
        send_req(REQ_FREE, 32'h108);

        // Zero slot size at the top of the address space: payload wraps
        drain_replies();
        program_slab(32'hFFFF_FFFF, 32'd0, 32'd3);
        end_cfg_writes();
        send_req(REQ_INIT, 32'h0);
        send_req(REQ_ALLOC, 32'h0);
        send_req(REQ_FREE, 32'h7);
        send_req(REQ_FREE, 32'hF);

        // Zero slot count: nothing to hand out, nothing in range
        drain_replies();
        write_slab_reg(CFG_COUNT, 32'd0);
        end_cfg_writes();
        send_req(REQ_INIT, 32'h0);
        send_req(REQ_ALLOC, 32'h0);
        send_req(REQ_FREE, 32'h108);

        // Random phases, each with its own layout
        for (phase = 0; phase < PHASES; phase++) begin
            drain_replies();
            case (phase)
                0: begin
                    idle_pct = 25;
                    program_slab(32'h0000_1000, 32'd64, 32'd16);
                end
                1: begin
                    idle_pct = 0;
                    program_slab(32'h0, 32'd8, 32'd1);
                end
                2: begin
                    idle_pct = 35;
                    program_slab(32'hFF00_0000, 32'h0001_0000, 32'd1024);
                end
                3: begin
                    idle_pct = 15;
                    program_slab($urandom, 8 * $urandom_range(1, 512), $urandom_range(1, 64));
                end
                4: begin
                    idle_pct = 20;
                    program_slab($urandom, 32'd0, 32'd8);
                end
                5: begin
                    idle_pct = 10;
                    program_slab($urandom, 32'd40, 32'd0);
                end
                6: begin
                    // junk in the upper data bits; count beyond the slots built
                    idle_pct = 20;
                    program_slab($urandom, {15'($urandom), 17'h1FFFF}, 32'hFFFF_FFFF);
                    write_slab_reg(CFG_SPARE, $urandom);
                end
                7: begin
                    idle_pct = 15;
                    program_slab($urandom, $urandom_range(1, 17'h1FFFF), $urandom_range(1, 40));
                end
                8: begin
                    idle_pct = 10;
                    program_slab($urandom, 32'd24, 32'd512);
                end
                default: begin
                    idle_pct = 0;
                    program_slab($urandom, 32'd72, 32'd32);
                end
            endcase
            end_cfg_writes();
            // phase 7 keeps the previous stack against a new count
            if (phase != 7) send_req(REQ_INIT, $urandom);
            if (phase == 8) hold_request = 1'b1;
            for (n = 0; n < PHASE_ITEMS; n++) send_random_item();
        end

        drain_replies();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (mismatches == 0 && outstanding == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
